FILE: rtl/cct_pkg.sv
package cct_pkg;

   // operand and product widths of the shared multiplier
   localparam int MUL_A_W = 18;
   localparam int MUL_B_W = 19;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   localparam logic [11:0] YEAR_MIN = 12'd2012;
   localparam logic [11:0] YEAR_MAX = 12'd2099;
   localparam logic [16:0] DAY_SECONDS = 17'd86400;

   // multiplier constants
   localparam logic [MUL_B_W-1:0] WD_MONTH_K = 19'd153;
   localparam logic [MUL_B_W-1:0] RECIP5_K   = 19'd13108;   // x/5 = (x*K)>>16
   localparam logic [MUL_B_W-1:0] WD_YEAR_K  = 19'd365;
   localparam logic [MUL_B_W-1:0] DAY_YEAR_K = 19'd367;
   localparam logic [MUL_B_W-1:0] RECIP7_K   = 19'd299594;  // x/7 = (x*K)>>21
   localparam logic [MUL_B_W-1:0] DAY_A_K    = 19'd7;
   localparam logic [MUL_B_W-1:0] MONTH_K    = 19'd275;
   localparam logic [MUL_B_W-1:0] RECIP9_K   = 19'd7282;    // x/9 = (x*K)>>16
   localparam logic [MUL_B_W-1:0] MIN_SECS_K = 19'd60;
   localparam logic [MUL_B_W-1:0] HOUR_SECS_K = 19'd3600;
   localparam logic [MUL_B_W-1:0] DAY_SECS_K = 19'd86400;

   localparam logic [31:0] WD_OFFSET  = 32'd621050;
   localparam logic [31:0] DAY_OFFSET = 32'd730531;

   typedef struct packed {
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [5:0]  day;
      logic [3:0]  month;
      logic [11:0] year;
      logic [2:0]  weekday;
      logic [8:0]  year_day;
      logic [31:0] epoch_secs;
      logic [16:0] day_secs;
      logic [15:0] epoch_days;
      logic        set_flag;
   } cal_state_type;

   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      if (month == 4'd2) begin
         len = leap ? 5'd29 : 5'd28;
      end else if (month inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
         len = 5'd30;
      end else if (month >= 4'd1 && month <= 4'd12) begin
         len = 5'd31;
      end else begin
         len = 5'd0;
      end
      return len;
   endfunction

   function automatic logic [8:0] days_before(input logic [3:0] month);
      logic [8:0] days;
      case (month)
         4'd1:    days = 9'd0;
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

FILE: rtl/cct_mul.sv
module cct_mul (
   input  logic                         clock,
   input  logic [cct_pkg::MUL_A_W-1:0]  mul_a,
   input  logic [cct_pkg::MUL_B_W-1:0]  mul_b,
   output logic [cct_pkg::PROD_W-1:0]   prod
);

   logic [cct_pkg::PROD_W-1:0] prod_ff;
   logic [cct_pkg::PROD_W-1:0] prod_in;

   assign prod_in = {{cct_pkg::MUL_B_W{1'b0}}, mul_a} * {{cct_pkg::MUL_A_W{1'b0}}, mul_b};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

FILE: rtl/cct_tick.sv
module cct_tick (
   input  cct_pkg::cal_state_type cur,
   output cct_pkg::cal_state_type nxt
);

   logic [6:0]  sec_inc;
   logic [6:0]  min_inc;
   logic [5:0]  hour_inc;
   logic [16:0] sod_inc;
   logic [5:0]  day_inc;
   logic [2:0]  wd_inc;
   logic [4:0]  cur_len;
   logic        month_ok;

   assign sec_inc  = {1'b0, cur.second} + 7'd1;
   assign min_inc  = {1'b0, cur.minute} + 7'd1;
   assign hour_inc = {1'b0, cur.hour} + 6'd1;
   assign sod_inc  = cur.day_secs + 17'd1;
   assign day_inc  = cur.day + 6'd1;
   assign wd_inc   = cur.weekday + 3'd1;
   assign cur_len  = cct_pkg::month_len(cur.month, cur.year[1:0] == 2'd0);
   assign month_ok = (cur.month >= 4'd1) && (cur.month <= 4'd12);

   always_comb begin
      nxt = cur;
      nxt.epoch_secs = cur.epoch_secs + 32'd1;
      nxt.day_secs   = sod_inc;

      // time of day with carries
      if (sec_inc >= 7'd60) begin
         nxt.second = '0;
         if (min_inc >= 7'd60) begin
            nxt.minute = '0;
            nxt.hour   = (hour_inc >= 6'd24) ? 5'd0 : hour_inc[4:0];
         end else begin
            nxt.minute = min_inc[5:0];
         end
      end else begin
         nxt.second = sec_inc[5:0];
      end

      // start a new day
      if (sod_inc >= cct_pkg::DAY_SECONDS) begin
         nxt.day_secs   = '0;
         nxt.day        = day_inc;
         nxt.weekday    = (wd_inc == 3'd7) ? 3'd0 : wd_inc;
         nxt.year_day   = cur.year_day + 9'd1;
         nxt.epoch_days = cur.epoch_days + 16'd1;
         if (month_ok) begin
            if (day_inc > {1'b0, cur_len}) begin
               nxt.day   = 6'd1;
               nxt.month = cur.month + 4'd1;
            end
            if (nxt.month > 4'd12) begin
               nxt.month    = 4'd1;
               nxt.year     = cur.year + 12'd1;
               nxt.year_day = 9'd1;
            end
         end
      end
   end

endmodule

FILE: rtl/calendar_clock_tick.sv
// Channel  | Direction | Handshake          | Payload
// req_     | in        | req_valid/req_stall| req_type, req_set_year .. req_set_second
// rsp_     | out       | rsp_valid/rsp_stall| rsp_cur_second .. rsp_is_set
//
// A tick item updates the calendar at its accept edge; the done state then moves
// it into the output register once that is free; req_ stalls until then.
// A set item runs 11 products through the one shared multiplier (one product per
// cycle, adds on the registered product) and a commit step; req_ stalls until the item is done.
// reset (synchronous, active high) clears the calendar to zero and empties the output.
// The next item is taken while a result waits; an item that finishes while
// rsp_stall holds the output register waits in place and stalls req_.
module calendar_clock_tick (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [15:0] req_set_year,
   input  logic [7:0]  req_set_month,
   input  logic [7:0]  req_set_day,
   input  logic [4:0]  req_set_hour,
   input  logic [5:0]  req_set_minute,
   input  logic [5:0]  req_set_second,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_cur_second,
   output logic [5:0]  rsp_cur_minute,
   output logic [4:0]  rsp_cur_hour,
   output logic [4:0]  rsp_cur_day,
   output logic [3:0]  rsp_cur_month,
   output logic [11:0] rsp_cur_year,
   output logic [2:0]  rsp_weekday,
   output logic [8:0]  rsp_year_day,
   output logic [31:0] rsp_total_seconds,
   output logic [15:0] rsp_total_days,
   output logic        rsp_is_set
);

   // sequencer states; each product step issues one product, and each step after the first takes up the last one
   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_WD_BASE   = 4'd1;
   localparam logic [3:0] ST_WD_DIV5   = 4'd2;
   localparam logic [3:0] ST_WD_YEAR   = 4'd3;
   localparam logic [3:0] ST_DAY_YEAR  = 4'd4;
   localparam logic [3:0] ST_WD_RECIP  = 4'd5;
   localparam logic [3:0] ST_WD_MOD    = 4'd6;
   localparam logic [3:0] ST_DAY_MONTH = 4'd7;
   localparam logic [3:0] ST_DAY_DIV9  = 4'd8;
   localparam logic [3:0] ST_SOD_MIN   = 4'd9;
   localparam logic [3:0] ST_SOD_HOUR  = 4'd10;
   localparam logic [3:0] ST_SEC_DAYS  = 4'd11;
   localparam logic [3:0] ST_COMMIT    = 4'd12;
   localparam logic [3:0] ST_DONE      = 4'd13;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   cct_pkg::cal_state_type cal_ff, cal_in, tick_next;
   cct_pkg::cal_state_type rsp_ff, rsp_in;

   // set operands; the date fields are clamped, the time fields are not
   logic [11:0] y_ff, y_in;
   logic [3:0]  m_ff, m_in;
   logic [4:0]  d_ff, d_in;
   logic [4:0]  h_ff, h_in;
   logic [5:0]  mi_ff, mi_in;
   logic [5:0]  s_ff, s_in;

   // accumulators: weekday sum then seconds of day, and day count
   logic [31:0] acc_ff, acc_in;
   logic [31:0] days_acc_ff, days_acc_in;
   logic [2:0]  wd_ff, wd_in;

   logic [cct_pkg::MUL_A_W-1:0] mul_a;
   logic [cct_pkg::MUL_B_W-1:0] mul_b;
   logic [cct_pkg::PROD_W-1:0]  prod;

   logic        req_accept;
   logic        rsp_free;
   logic [11:0] y_cl;
   logic [3:0]  m_cl;
   logic [4:0]  len_cl;
   logic [4:0]  d_cl;
   logic        after_feb;
   logic [11:0] ny;
   logic [3:0]  nm;
   logic [11:0] a_term;
   logic        leap_adj;

   cct_tick u_tick (
      .cur (cal_ff),
      .nxt (tick_next)
   );

   cct_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // clamp the requested date
   always_comb begin
      if (req_set_year < 16'(cct_pkg::YEAR_MIN)) begin
         y_cl = cct_pkg::YEAR_MIN;
      end else if (req_set_year > 16'(cct_pkg::YEAR_MAX)) begin
         y_cl = cct_pkg::YEAR_MAX;
      end else begin
         y_cl = req_set_year[11:0];
      end
      if (req_set_month < 8'd1) begin
         m_cl = 4'd1;
      end else if (req_set_month > 8'd12) begin
         m_cl = 4'd12;
      end else begin
         m_cl = req_set_month[3:0];
      end
      len_cl = cct_pkg::month_len(m_cl, y_cl[1:0] == 2'd0);
      if (req_set_day < 8'd1) begin
         d_cl = 5'd1;
      end else if (req_set_day > {3'b0, len_cl}) begin
         d_cl = len_cl;
      end else begin
         d_cl = req_set_day[4:0];
      end
   end

   // March-based year and month for the weekday sum
   assign after_feb = (m_ff > 4'd2);
   assign ny        = after_feb ? y_ff : y_ff - 12'd1;
   assign nm        = after_feb ? m_ff + 4'd1 : m_ff + 4'd13;
   assign a_term    = y_ff + {11'b0, after_feb};
   assign leap_adj  = after_feb && (y_ff[1:0] == 2'd0);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      cal_in       = cal_ff;
      y_in         = y_ff;
      m_in         = m_ff;
      d_in         = d_ff;
      h_in         = h_ff;
      mi_in        = mi_ff;
      s_in         = s_ff;
      acc_in       = acc_ff;
      days_acc_in  = days_acc_ff;
      wd_in        = wd_ff;
      mul_a        = '0;
      mul_b        = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_type) begin
                  // hold the clamped operands for the sequence
                  y_in     = y_cl;
                  m_in     = m_cl;
                  d_in     = d_cl;
                  h_in     = req_set_hour;
                  mi_in    = req_set_minute;
                  s_in     = req_set_second;
                  state_in = ST_WD_BASE;
               end else begin
                  cal_in   = tick_next;
                  state_in = ST_DONE;
               end
            end
         end
         ST_WD_BASE: begin
            mul_a    = 18'(nm);
            mul_b    = cct_pkg::WD_MONTH_K;
            acc_in   = 32'(ny[11:2]) + 32'(d_ff) - cct_pkg::WD_OFFSET;
            state_in = ST_WD_DIV5;
         end
         ST_WD_DIV5: begin
            mul_a    = prod[17:0];
            mul_b    = cct_pkg::RECIP5_K;
            state_in = ST_WD_YEAR;
         end
         ST_WD_YEAR: begin
            mul_a    = 18'(ny);
            mul_b    = cct_pkg::WD_YEAR_K;
            acc_in   = acc_ff + 32'(prod[31:16]);
            state_in = ST_DAY_YEAR;
         end
         ST_DAY_YEAR: begin
            mul_a    = 18'(y_ff);
            mul_b    = cct_pkg::DAY_YEAR_K;
            acc_in   = acc_ff + prod[31:0];
            state_in = ST_WD_RECIP;
         end
         ST_WD_RECIP: begin
            // acc now holds the weekday day number
            mul_a       = acc_ff[17:0];
            mul_b       = cct_pkg::RECIP7_K;
            days_acc_in = prod[31:0] + 32'(d_ff) - cct_pkg::DAY_OFFSET;
            state_in    = ST_WD_MOD;
         end
         ST_WD_MOD: begin
            // n - 7q in three bits is n + q
            mul_a    = 18'(a_term);
            mul_b    = cct_pkg::DAY_A_K;
            wd_in    = acc_ff[2:0] + prod[23:21];
            state_in = ST_DAY_MONTH;
         end
         ST_DAY_MONTH: begin
            mul_a       = 18'(m_ff);
            mul_b       = cct_pkg::MONTH_K;
            days_acc_in = days_acc_ff - 32'(prod[31:2]);
            state_in    = ST_DAY_DIV9;
         end
         ST_DAY_DIV9: begin
            mul_a    = prod[17:0];
            mul_b    = cct_pkg::RECIP9_K;
            state_in = ST_SOD_MIN;
         end
         ST_SOD_MIN: begin
            mul_a       = 18'(mi_ff);
            mul_b       = cct_pkg::MIN_SECS_K;
            days_acc_in = days_acc_ff + 32'(prod[31:16]);
            state_in    = ST_SOD_HOUR;
         end
         ST_SOD_HOUR: begin
            mul_a    = 18'(h_ff);
            mul_b    = cct_pkg::HOUR_SECS_K;
            acc_in   = prod[31:0] + 32'(s_ff);
            state_in = ST_SEC_DAYS;
         end
         ST_SEC_DAYS: begin
            mul_a    = 18'(days_acc_ff[15:0]);
            mul_b    = cct_pkg::DAY_SECS_K;
            acc_in   = acc_ff + prod[31:0];
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cal_in.year       = y_ff;
            cal_in.month      = m_ff;
            cal_in.day        = {1'b0, d_ff};
            cal_in.hour       = h_ff;
            cal_in.minute     = mi_ff;
            cal_in.second     = s_ff;
            cal_in.weekday    = wd_ff;
            cal_in.year_day   = cct_pkg::days_before(m_ff) + 9'(d_ff) + 9'(leap_adj);
            cal_in.epoch_days = days_acc_ff[15:0];
            cal_in.epoch_secs = prod[31:0] + acc_ff;
            cal_in.day_secs   = acc_ff[16:0];
            cal_in.set_flag   = 1'b1;
            state_in          = ST_DONE;
         end
         ST_DONE: begin
            // drop the finished state into the output register once it is free
            if (rsp_free) begin
               rsp_in       = cal_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cal_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cal_ff       <= cal_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff      <= rsp_in;
      y_ff        <= y_in;
      m_ff        <= m_in;
      d_ff        <= d_in;
      h_ff        <= h_in;
      mi_ff       <= mi_in;
      s_ff        <= s_in;
      acc_ff      <= acc_in;
      days_acc_ff <= days_acc_in;
      wd_ff       <= wd_in;
   end

   // result fields; totals fall back to day-local counts before the first set
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cur_second    = rsp_ff.second;
   assign rsp_cur_minute    = rsp_ff.minute;
   assign rsp_cur_hour      = rsp_ff.hour;
   assign rsp_cur_day       = rsp_ff.day[4:0];
   assign rsp_cur_month     = rsp_ff.month;
   assign rsp_cur_year      = rsp_ff.year;
   assign rsp_weekday       = rsp_ff.weekday;
   assign rsp_year_day      = rsp_ff.year_day;
   assign rsp_total_seconds = rsp_ff.set_flag ? rsp_ff.epoch_secs : {15'b0, rsp_ff.day_secs};
   assign rsp_total_days    = rsp_ff.set_flag ? rsp_ff.epoch_days : {7'b0, rsp_ff.year_day};
   assign rsp_is_set        = rsp_ff.set_flag;

   a_set_starts_sequence: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_type) |=> (state_ff == ST_WD_BASE))
      else $error("set item did not enter the arithmetic sequence");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the done state");

   a_weekday_range: assert property (@(posedge clock) disable iff (reset)
      cal_ff.weekday != 3'd7)
      else $error("weekday left the range 0..6");

   a_set_flag_sticks: assert property (@(posedge clock) disable iff (reset)
      !$fell(cal_ff.set_flag))
      else $error("set flag cleared without reset");

endmodule

FILE: tb/sv/calendar_clock_tick_tb.sv
module calendar_clock_tick_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // stimulus sizes
   localparam int RANDOM_ITEMS   = 1850;
   // a few ticks on the unset calendar before the first date is loaded
   localparam int UNSET_TICKS    = 20;
   localparam int DRAIN_CYCLES   = 40;
   localparam int PRINT_LIMIT    = 50;

   typedef enum bit {REQ_TICK = 1'b0, REQ_SET = 1'b1} req_kind_type;

   typedef struct {
      req_kind_type kind;
      bit [15:0]    year;
      bit [7:0]     month;
      bit [7:0]     day;
      bit [4:0]     hour;
      bit [5:0]     minute;
      bit [5:0]     second;
   } cal_request_type;

   typedef struct {
      bit [5:0]   second;
      bit [5:0]   minute;
      bit [4:0]   hour;
      bit [4:0]   day;
      bit [3:0]   month;
      bit [11:0]  year;
      bit [2:0]   weekday;
      bit [8:0]   year_day;
      bit [31:0]  total_seconds;
      bit [15:0]  total_days;
      bit         is_set;
   } cal_snapshot_type;

   // Calendar predictor plus the queue of snapshots the block still owes us.
   class cal_scoreboard;
      cct_pkg::cal_state_type cal;
      cal_snapshot_type       owed_snapshots[$];
      int unsigned            mismatches;
      int unsigned            month_length_tab[12] = '{31, 28, 31, 30, 31, 30,
                                                       31, 31, 30, 31, 30, 31};
      int unsigned            days_ahead_tab[12]   = '{0, 31, 59, 90, 120, 151,
                                                       181, 212, 243, 273, 304, 334};

      function new();
         cal        = '0;
         mismatches = 0;
      endfunction

      task report_mismatch(string what);
         if (mismatches < PRINT_LIMIT) begin
            $display("%0t mismatch: %s", $realtime, what);
         end
         mismatches++;
      endtask

      function int unsigned pending();
         return owed_snapshots.size();
      endfunction

      function int unsigned month_days(int unsigned m, int unsigned y);
         if (m < 1 || m > 12) begin
            return 0;
         end
         if (m == 2 && (y % 4) == 0) begin
            return 29;
         end
         return month_length_tab[m - 1];
      endfunction

      function void roll_day();
         cal.day        = cal.day + 1'b1;
         cal.weekday    = cal.weekday + 1'b1;
         cal.year_day   = cal.year_day + 1'b1;
         cal.epoch_days = cal.epoch_days + 1'b1;
         if (cal.weekday > 3'd6) begin
            cal.weekday = '0;
         end
         // month and year stay put until a date has been loaded
         if (cal.month >= 4'd1 && cal.month <= 4'd12) begin
            if (cal.day > month_days(cal.month, cal.year)) begin
               cal.day   = 6'd1;
               cal.month = cal.month + 1'b1;
            end
            if (cal.month > 4'd12) begin
               cal.month    = 4'd1;
               cal.year     = cal.year + 1'b1;
               cal.year_day = 9'd1;
            end
         end
      endfunction

      function void advance_second();
         int unsigned s;
         int unsigned mi;
         int unsigned h;
         cal.epoch_secs = cal.epoch_secs + 1'b1;
         cal.day_secs   = cal.day_secs + 1'b1;
         // carry in full integers: a loaded 63 must still carry on 64
         s = cal.second + 1;
         if (s >= 60) begin
            cal.second = '0;
            mi = cal.minute + 1;
            if (mi >= 60) begin
               cal.minute = '0;
               h = cal.hour + 1;
               cal.hour = (h >= 24) ? 5'd0 : h[4:0];
            end else begin
               cal.minute = mi[5:0];
            end
         end else begin
            cal.second = s[5:0];
         end
         if (cal.day_secs >= cct_pkg::DAY_SECONDS) begin
            cal.day_secs = '0;
            roll_day();
         end
      endfunction

      function void load_date(cal_request_type r);
         int unsigned y;
         int unsigned m;
         int unsigned d;
         int unsigned len;
         int unsigned ny;
         int unsigned nm;
         int unsigned n;
         int unsigned doy;
         int unsigned a;
         int unsigned days;
         int unsigned sod;
         y = r.year;
         m = r.month;
         d = r.day;
         if (y < cct_pkg::YEAR_MIN) y = cct_pkg::YEAR_MIN;
         if (y > cct_pkg::YEAR_MAX) y = cct_pkg::YEAR_MAX;
         if (m < 1) m = 1;
         if (m > 12) m = 12;
         len = month_days(m, y);
         if (d < 1) d = 1;
         if (d > len) d = len;
         // January and February count as months 13 and 14 of the year before
         if (m > 2) begin
            nm = m + 1;
            ny = y;
         end else begin
            nm = m + 13;
            ny = y - 1;
         end
         n   = 365 * ny + ny / 4 + (153 * nm) / 5 + d - 621050;
         doy = days_ahead_tab[m - 1] + d;
         if (m > 2 && (y % 4) == 0) begin
            doy = doy + 1;
         end
         a    = y + (m + 9) / 12;
         days = 367 * y - (7 * a) / 4 + (275 * m) / 9 + d - 730531;
         sod  = r.hour * 3600 + r.minute * 60 + r.second;

         cal.set_flag   = 1'b1;
         cal.year       = y[11:0];
         cal.month      = m[3:0];
         cal.day        = d[5:0];
         cal.hour       = r.hour;
         cal.minute     = r.minute;
         cal.second     = r.second;
         cal.weekday    = 3'(n % 7);
         cal.year_day   = doy[8:0];
         cal.epoch_days = days[15:0];
         cal.epoch_secs = days * 86400 + sod;
         cal.day_secs   = sod[16:0];
      endfunction

      function void note_request(cal_request_type r);
         cal_snapshot_type snap;
         if (r.kind == REQ_SET) begin
            load_date(r);
         end else begin
            advance_second();
         end
         snap.second        = cal.second;
         snap.minute        = cal.minute;
         snap.hour          = cal.hour;
         snap.day           = cal.day[4:0];
         snap.month         = cal.month;
         snap.year          = cal.year;
         snap.weekday       = cal.weekday;
         snap.year_day      = cal.year_day;
         snap.total_seconds = cal.set_flag ? cal.epoch_secs : {15'd0, cal.day_secs};
         snap.total_days    = cal.set_flag ? cal.epoch_days : {7'd0, cal.year_day};
         snap.is_set        = cal.set_flag;
         owed_snapshots.push_back(snap);
      endfunction

      task compare_field(string name, int unsigned got, int unsigned want);
         if (got != want) begin
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
         end
      endtask

      task check_response(cal_snapshot_type got);
         cal_snapshot_type want;
         if (owed_snapshots.size() == 0) begin
            report_mismatch("result with nothing outstanding");
         end else begin
            want = owed_snapshots.pop_front();
            compare_field("cur_second", got.second, want.second);
            compare_field("cur_minute", got.minute, want.minute);
            compare_field("cur_hour", got.hour, want.hour);
            compare_field("cur_day", got.day, want.day);
            compare_field("cur_month", got.month, want.month);
            compare_field("cur_year", got.year, want.year);
            compare_field("weekday", got.weekday, want.weekday);
            compare_field("year_day", got.year_day, want.year_day);
            compare_field("total_seconds", got.total_seconds, want.total_seconds);
            compare_field("total_days", got.total_days, want.total_days);
            compare_field("is_set", got.is_set, want.is_set);
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;

   logic        req_valid;
   logic        req_stall;
   logic        req_type;
   logic [15:0] req_set_year;
   logic [7:0]  req_set_month;
   logic [7:0]  req_set_day;
   logic [4:0]  req_set_hour;
   logic [5:0]  req_set_minute;
   logic [5:0]  req_set_second;

   logic        rsp_valid;
   logic        rsp_stall;
   logic [5:0]  rsp_cur_second;
   logic [5:0]  rsp_cur_minute;
   logic [4:0]  rsp_cur_hour;
   logic [4:0]  rsp_cur_day;
   logic [3:0]  rsp_cur_month;
   logic [11:0] rsp_cur_year;
   logic [2:0]  rsp_weekday;
   logic [8:0]  rsp_year_day;
   logic [31:0] rsp_total_seconds;
   logic [15:0] rsp_total_days;
   logic        rsp_is_set;

   // idling percentages of the current phase, one for each side
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;

   cal_scoreboard sb = new();

   calendar_clock_tick i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_set_year      (req_set_year),
      .req_set_month     (req_set_month),
      .req_set_day       (req_set_day),
      .req_set_hour      (req_set_hour),
      .req_set_minute    (req_set_minute),
      .req_set_second    (req_set_second),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cur_second    (rsp_cur_second),
      .rsp_cur_minute    (rsp_cur_minute),
      .rsp_cur_hour      (rsp_cur_hour),
      .rsp_cur_day       (rsp_cur_day),
      .rsp_cur_month     (rsp_cur_month),
      .rsp_cur_year      (rsp_cur_year),
      .rsp_weekday       (rsp_weekday),
      .rsp_year_day      (rsp_year_day),
      .rsp_total_seconds (rsp_total_seconds),
      .rsp_total_days    (rsp_total_days),
      .rsp_is_set        (rsp_is_set)
   );

   always #4 clock = ~clock;

   // Present one item and hold it until the block takes it. Idle cycles come
   // first, one coin toss per cycle, so gaps land on every phase of the work.
   task automatic push_item(cal_request_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= r.kind;
      req_set_year   <= r.year;
      req_set_month  <= r.month;
      req_set_day    <= r.day;
      req_set_hour   <= r.hour;
      req_set_minute <= r.minute;
      req_set_second <= r.second;
      // stall read here is the value the block showed at this edge
      do begin
         @(posedge clock);
      end while (req_stall);
      sb.note_request(r);
   endtask

   // A tick ignores the set fields; fill them with junk anyway.
   task automatic send_tick();
      cal_request_type r;
      r.kind   = REQ_TICK;
      r.year   = 16'($urandom);
      r.month  = 8'($urandom);
      r.day    = 8'($urandom);
      r.hour   = 5'($urandom);
      r.minute = 6'($urandom);
      r.second = 6'($urandom);
      push_item(r);
   endtask

   task automatic send_set(int unsigned y, int unsigned m, int unsigned d,
                           int unsigned h, int unsigned mi, int unsigned s);
      cal_request_type r;
      r.kind   = REQ_SET;
      r.year   = y[15:0];
      r.month  = m[7:0];
      r.day    = d[7:0];
      r.hour   = h[4:0];
      r.minute = mi[5:0];
      r.second = s[5:0];
      push_item(r);
   endtask

   // Random set item, biased toward month ends and the last seconds of a day
   // so that the following ticks walk through rollovers.
   function automatic cal_request_type random_set();
      cal_request_type r;
      int unsigned     k;
      r.kind = REQ_SET;
      k = $urandom_range(0, 99);
      if (k < 70) begin
         r.year = 16'($urandom_range(2012, 2099));
      end else if (k < 85) begin
         r.year = 16'($urandom);
      end else begin
         case ($urandom_range(0, 5))
            0:       r.year = 16'd0;
            1:       r.year = 16'd2011;
            2:       r.year = 16'd2012;
            3:       r.year = 16'd2099;
            4:       r.year = 16'd2100;
            default: r.year = 16'hFFFF;
         endcase
      end
      k = $urandom_range(0, 99);
      r.month = (k < 75) ? 8'($urandom_range(1, 12)) : 8'($urandom);
      k = $urandom_range(0, 99);
      if (k < 45) begin
         r.day = 8'($urandom_range(28, 31));
      end else if (k < 75) begin
         r.day = 8'($urandom_range(1, 31));
      end else begin
         r.day = 8'($urandom);
      end
      k = $urandom_range(0, 99);
      if (k < 45) begin
         r.hour   = 5'd23;
         r.minute = 6'd59;
         r.second = 6'($urandom_range(45, 59));
      end else if (k < 80) begin
         r.hour   = 5'($urandom_range(0, 23));
         r.minute = 6'($urandom_range(0, 59));
         r.second = 6'($urandom_range(0, 59));
      end else begin
         // out-of-range time fields: the day can start late and carry oddly
         r.hour   = 5'($urandom);
         r.minute = 6'($urandom);
         r.second = 6'($urandom);
      end
      return r;
   endfunction

   // Result side: sample at the edge, then choose the stall for the next cycle.
   initial begin : result_side
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
            sb.check_response('{second:        rsp_cur_second,
                                minute:        rsp_cur_minute,
                                hour:          rsp_cur_hour,
                                day:           rsp_cur_day,
                                month:         rsp_cur_month,
                                year:          rsp_cur_year,
                                weekday:       rsp_weekday,
                                year_day:      rsp_year_day,
                                total_seconds: rsp_total_seconds,
                                total_days:    rsp_total_days,
                                is_set:        rsp_is_set});
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   initial begin : stimulus
      int unsigned     sent;
      int unsigned     phase;
      int unsigned     ticks;
      cal_request_type r;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = REQ_TICK;
      req_set_year   = '0;
      req_set_month  = '0;
      req_set_day    = '0;
      req_set_hour   = '0;
      req_set_minute = '0;
      req_set_second = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Unset calendar: count a few seconds while the month is still zero.
      for (int i = 0; i < UNSET_TICKS; i++) begin
         send_tick();
      end

      // Clamp to the low corner, then to the high corner with a bad time.
      send_set(0, 0, 0, 0, 0, 0);
      send_tick();
      send_set(16'hFFFF, 8'hFF, 8'hFF, 31, 63, 63);
      // day count already past a full day: roll into a year beyond 2099
      send_tick();
      send_tick();
      // leap and common February ends
      send_set(2012, 2, 28, 23, 59, 59);
      send_tick();
      send_set(2013, 2, 28, 23, 59, 59);
      send_tick();
      send_set(2016, 2, 31, 23, 59, 59);
      send_tick();
      // thirty-day month end and the year clamps just outside the range
      send_set(2020, 4, 30, 23, 59, 59);
      send_tick();
      send_set(2011, 13, 1, 0, 0, 0);
      send_set(2100, 6, 0, 12, 0, 0);
      // March in a leap year picks up the extra day of year
      send_set(2024, 3, 1, 12, 34, 56);
      send_tick();
      // minute and hour carries from the last second of the range
      send_set(2099, 12, 31, 23, 59, 58);
      send_tick();
      send_tick();
      send_set(2050, 7, 15, 10, 59, 59);
      send_tick();

      // Random part: mostly a set followed by a run of ticks, some noise.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         phase = (sent * 4) / RANDOM_ITEMS;
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 52;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 52;
            end
            default: begin
               send_idle_pct = 17;
               stall_pct     = 17;
            end
         endcase
         if ($urandom_range(0, 99) < 15) begin
            r.kind   = req_kind_type'($urandom_range(0, 1));
            r.year   = 16'($urandom);
            r.month  = 8'($urandom);
            r.day    = 8'($urandom);
            r.hour   = 5'($urandom);
            r.minute = 6'($urandom);
            r.second = 6'($urandom);
            push_item(r);
            sent++;
         end else begin
            push_item(random_set());
            sent++;
            ticks = ($urandom_range(0, 99) < 10) ? $urandom_range(40, 70)
                                                 : $urandom_range(1, 6);
            for (int i = 0; i < ticks; i++) begin
               send_tick();
               sent++;
            end
         end
      end
      req_valid <= 1'b0;

      // drain, then give any stray result time to show up
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // hard stop well past the slowest legal run
   initial begin : watchdog
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
